/* rtl/core/rlss_pkg.sv */
// Package for the random looping shift sequencer.
// Holds the LCG step and residue functions, reset constants, mode codes,
// configuration register indexes and the mapper result type. No dependencies.
package rlss_pkg;

    // Linear congruential generator constants.
    localparam logic [31:0] LCG_MUL   = 32'd1664525;
    localparam logic [31:0] LCG_ADD   = 32'd1013904223;
    localparam logic [31:0] SEED_INIT = 32'd20071204;

    // Reciprocal of 100 scaled by 2^37, exact for every 32-bit dividend.
    localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
    localparam int unsigned RECIP_SHIFT = 37;

    // Loop register value after reset.
    localparam logic [15:0] LOOP_INIT = 16'h8000;

    // One step of the generator, modulo 2^32.
    function automatic logic [31:0] lcg_next(input logic [31:0] w);
        logic [31:0] prod;
        prod = w * LCG_MUL;
        return prod + LCG_ADD;
    endfunction

    // Remainder of a 32-bit word by 100, through a reciprocal multiply.
    function automatic logic [6:0] mod100(input logic [31:0] w);
        logic [63:0] prod;
        logic [31:0] quo;
        logic [31:0] rem;
        prod = 64'(w) * 64'(RECIP_100);
        quo  = 32'(prod[63:RECIP_SHIFT]);
        rem  = w - ((quo << 6) + (quo << 5) + (quo << 2));
        return rem[6:0];
    endfunction

    // Generator lookahead after reset: the next word, its residue, and the one after.
    localparam logic [31:0] W1_INIT = lcg_next(SEED_INIT);
    localparam logic [6:0]  M1_INIT = mod100(W1_INIT);
    localparam logic [31:0] W2_INIT = lcg_next(W1_INIT);

    // Output mapping mode codes.
    localparam logic [4:0] GATE_MODES = 5'd15;
    localparam logic [4:0] MODE_CV    = 5'd15;
    localparam logic [4:0] MODE_NOTE7 = 5'd16;
    localparam logic [4:0] MODE_NOTE6 = 5'd17;
    localparam logic [4:0] MODE_NOTE5 = 5'd18;
    localparam logic [4:0] MODE_NOTE4 = 5'd19;
    localparam logic [4:0] MODE_NOTE3 = 5'd20;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_FLIP_PERCENT = 3'd0,
        CFG_LOOP_LENGTH  = 3'd1,
        CFG_OUT1_MODE    = 3'd2,
        CFG_OUT2_MODE    = 3'd3,
        CFG_GATE_LEVEL   = 3'd4,
        CFG_CV_STEP      = 3'd5,
        CFG_INITIAL_SEED = 3'd6
    } cfg_index_t;

    // Result of one output mapper.
    typedef struct packed {
        logic signed [15:0] value;
        logic               gate;
        logic               is_note;
    } map_out_t;

endpackage

/* rtl/core/rlss_map.sv */
// Output mapper: turns the pattern byte into a gate, scaled CV or note value.
// Depends on rlss_pkg for mode codes and the map_out_t result type.
module rlss_map
(
    input  logic [4:0]         mode,
    input  logic [7:0]         pattern,
    input  logic [14:0]        gate_level,
    input  logic [7:0]         cv_step,
    input  logic signed [15:0] cv_offset,
    output rlss_pkg::map_out_t result
);

    // Gate mask for each gate mode.
    function automatic logic [7:0] gate_mask(input logic [3:0] m);
        logic [7:0] mask;
        unique case (m)
            4'd0:    mask = 8'h80;
            4'd1:    mask = 8'hC0;
            4'd2:    mask = 8'hC0;
            4'd3:    mask = 8'h40;
            4'd4:    mask = 8'h50;
            4'd5:    mask = 8'h50;
            4'd6:    mask = 8'h20;
            4'd7:    mask = 8'h10;
            4'd8:    mask = 8'h08;
            4'd9:    mask = 8'h12;
            4'd10:   mask = 8'h12;
            4'd11:   mask = 8'h04;
            4'd12:   mask = 8'hD2;
            4'd13:   mask = 8'hD2;
            4'd14:   mask = 8'h02;
            default: mask = 8'h00;
        endcase
        return mask;
    endfunction

    // Modes whose gate needs all mask bits set rather than any of them.
    localparam logic [14:0] GATE_ALL = 15'b110_1101_1110_0100;

    logic [7:0]         mask;
    logic               gate_hi;
    logic [15:0]        prod;
    logic signed [17:0] cv_sum;
    logic [7:0]         note;

    always_comb
    begin
        mask = gate_mask(mode[3:0]);
        if (GATE_ALL[mode[3:0]])
        begin
            gate_hi = (pattern & mask) == mask;
        end
        else
        begin
            gate_hi = (pattern & mask) != 8'd0;
        end

        // Scaled CV; any undefined mode passes the offset alone.
        prod   = (mode == rlss_pkg::MODE_CV) ? (16'(pattern) * 16'(cv_step)) : 16'd0;
        cv_sum = $signed({2'b00, prod}) + 18'(cv_offset);

        unique case (mode)
            rlss_pkg::MODE_NOTE7: note = {1'b0, pattern[6:0]};
            rlss_pkg::MODE_NOTE6: note = 8'd64 + {2'b00, pattern[5:0]};
            rlss_pkg::MODE_NOTE5: note = 8'd64 + {3'b000, pattern[4:0]};
            rlss_pkg::MODE_NOTE4: note = 8'd64 + {4'b0000, pattern[3:0]};
            rlss_pkg::MODE_NOTE3: note = 8'd64 + {5'b00000, pattern[2:0]};
            default:              note = 8'd0;
        endcase

        result = '0;
        priority if (mode < rlss_pkg::GATE_MODES)
        begin
            result.gate  = gate_hi;
            result.value = gate_hi ? $signed({1'b0, gate_level}) : 16'sd0;
        end
        else if (mode >= rlss_pkg::MODE_NOTE7 && mode <= rlss_pkg::MODE_NOTE3)
        begin
            result.is_note = 1'b1;
            result.value   = $signed({8'd0, note});
        end
        else if (cv_sum > 18'sd32767)
        begin
            result.value = 16'sh7FFF;
        end
        else if (cv_sum < -18'sd32768)
        begin
            result.value = 16'sh8000;
        end
        else
        begin
            result.value = cv_sum[15:0];
        end
    end

endmodule

/* rtl/core/random_looping_shift_sequencer.sv */
// Top level of the random looping shift sequencer: loop register, generator
// lookahead, snapshot logic, configuration registers and result register.
// Depends on rlss_pkg and rlss_map.
//
//  Channel  | Signals                                       | Handshake
//  ---------+-----------------------------------------------+--------------------
//  item     | restore, cv_offset                            | item_valid / item_stall
//  result   | pattern_byte, out1_*, out2_*                  | result_valid / result_stall
//  config   | cfg_index, cfg_data                           | cfg_valid / cfg_ready
//
// One item is taken per cycle while item_stall is low; its result appears in the result register in the next cycle.
// The loop bit depends only on a precomputed residue, so the generator multiply and
// the mod-100 reciprocal multiply run one step ahead and never limit the rate.
// item_stall is high only while a result waits and result_stall is high.
// Reset acts at once and initialises all state but the result payload; cfg_ready is always high.
module random_looping_shift_sequencer
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               item_valid,
    output logic               item_stall,
    input  logic               restore,
    input  logic signed [15:0] cv_offset,

    output logic               result_valid,
    input  logic               result_stall,
    output logic [7:0]         pattern_byte,
    output logic signed [15:0] out1_value,
    output logic               out1_gate,
    output logic               out1_is_note,
    output logic signed [15:0] out2_value,
    output logic               out2_gate,
    output logic               out2_is_note,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // Configuration registers.
    logic [6:0]  flip_percent_reg;
    logic [4:0]  loop_length_reg;
    logic [4:0]  out1_mode_reg;
    logic [4:0]  out2_mode_reg;
    logic [14:0] gate_level_reg;
    logic [7:0]  cv_step_reg;

    // Sequencer state. w1 is the next generator word, m1 its residue, w2 the one after.
    logic [15:0] loop_bits_reg;
    logic [31:0] w1_reg;
    logic [6:0]  m1_reg;
    logic [31:0] w2_reg;
    logic [15:0] saved_bits_reg;
    logic [31:0] sw1_reg;
    logic [6:0]  sm1_reg;
    logic [31:0] sw2_reg;
    logic [6:0]  seen_percent_reg;
    logic [4:0]  seen_length_reg;
    logic        started_reg;

    // Result register.
    logic        result_valid_reg;
    logic [7:0]  pattern_byte_reg;
    rlss_pkg::map_out_t out1_reg;
    rlss_pkg::map_out_t out2_reg;

    logic        item_accept;
    logic        take_snapshot;
    logic        use_saved;
    logic [15:0] src_bits;
    logic [6:0]  src_m1;
    logic [31:0] src_w2;
    logic [4:0]  len_eff;
    logic [3:0]  tap_idx;
    logic        loop_bit;
    logic [15:0] loop_bits_next;
    rlss_pkg::map_out_t out1_next;
    rlss_pkg::map_out_t out2_next;

    // Handshakes.
    assign item_stall  = result_valid_reg & result_stall;
    assign item_accept = item_valid & ~item_stall;
    assign cfg_ready   = 1'b1;

    // Configuration writes; the initial seed is a package constant used only at reset, so its write is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_percent_reg <= 7'd50;
            loop_length_reg  <= 5'd8;
            out1_mode_reg    <= 5'd0;
            out2_mode_reg    <= 5'd15;
            gate_level_reg   <= 15'd7680;
            cv_step_reg      <= 8'd30;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rlss_pkg::cfg_index_t'(cfg_index))
                rlss_pkg::CFG_FLIP_PERCENT: flip_percent_reg <= cfg_data[6:0];
                rlss_pkg::CFG_LOOP_LENGTH:  loop_length_reg  <= cfg_data[4:0];
                rlss_pkg::CFG_OUT1_MODE:    out1_mode_reg    <= cfg_data[4:0];
                rlss_pkg::CFG_OUT2_MODE:    out2_mode_reg    <= cfg_data[4:0];
                rlss_pkg::CFG_GATE_LEVEL:   gate_level_reg   <= cfg_data[14:0];
                rlss_pkg::CFG_CV_STEP:      cv_step_reg      <= cfg_data[7:0];
                rlss_pkg::CFG_INITIAL_SEED: ;
                default: ;
            endcase
        end
    end

    // Step logic: snapshot check, restore selection, tap, flip and shift.
    always_comb
    begin
        take_snapshot = started_reg &&
                        (seen_percent_reg != flip_percent_reg ||
                         seen_length_reg != loop_length_reg);
        use_saved = restore && !take_snapshot;

        src_bits = use_saved ? saved_bits_reg : loop_bits_reg;
        src_m1   = use_saved ? sm1_reg : m1_reg;
        src_w2   = use_saved ? sw2_reg : w2_reg;

        priority if (loop_length_reg == 5'd0)
        begin
            len_eff = 5'd1;
        end
        else if (loop_length_reg > 5'd16)
        begin
            len_eff = 5'd16;
        end
        else
        begin
            len_eff = loop_length_reg;
        end
        tap_idx = 4'(5'd16 - len_eff);

        loop_bit       = src_bits[tap_idx] ^ (src_m1 < flip_percent_reg);
        loop_bits_next = {loop_bit, src_bits[15:1]};
    end

    // Sequencer state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_bits_reg    <= rlss_pkg::LOOP_INIT;
            w1_reg           <= rlss_pkg::W1_INIT;
            m1_reg           <= rlss_pkg::M1_INIT;
            w2_reg           <= rlss_pkg::W2_INIT;
            saved_bits_reg   <= 16'd0;
            sw1_reg          <= rlss_pkg::W1_INIT;
            sm1_reg          <= rlss_pkg::M1_INIT;
            sw2_reg          <= rlss_pkg::W2_INIT;
            seen_percent_reg <= 7'd0;
            seen_length_reg  <= 5'd0;
            started_reg      <= 1'b0;
        end
        else if (item_accept)
        begin
            if (take_snapshot)
            begin
                saved_bits_reg <= loop_bits_reg;
                sw1_reg        <= w1_reg;
                sm1_reg        <= m1_reg;
                sw2_reg        <= w2_reg;
            end
            started_reg      <= 1'b1;
            seen_percent_reg <= flip_percent_reg;
            seen_length_reg  <= loop_length_reg;
            loop_bits_reg    <= loop_bits_next;
            w1_reg           <= src_w2;
            m1_reg           <= rlss_pkg::mod100(src_w2);
            w2_reg           <= rlss_pkg::lcg_next(src_w2);
        end
    end

    // Output mappers.
    rlss_map u_map1
    (
        .mode       (out1_mode_reg),
        .pattern    (loop_bits_next[15:8]),
        .gate_level (gate_level_reg),
        .cv_step    (cv_step_reg),
        .cv_offset  (cv_offset),
        .result     (out1_next)
    );

    rlss_map u_map2
    (
        .mode       (out2_mode_reg),
        .pattern    (loop_bits_next[15:8]),
        .gate_level (gate_level_reg),
        .cv_step    (cv_step_reg),
        .cv_offset  (cv_offset),
        .result     (out2_next)
    );

    // Result register valid: loaded on a new transaction, cleared when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            pattern_byte_reg <= loop_bits_next[15:8];
            out1_reg         <= out1_next;
            out2_reg         <= out2_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign pattern_byte = pattern_byte_reg;
    assign out1_value   = out1_reg.value;
    assign out1_gate    = out1_reg.gate;
    assign out1_is_note = out1_reg.is_note;
    assign out2_value   = out2_reg.value;
    assign out2_gate    = out2_reg.gate;
    assign out2_is_note = out2_reg.is_note;

    // The live generator lookahead stays consistent with its word.
    a_live_lookahead: assert property (@(posedge clk) disable iff (!rst_n)
        (w2_reg == rlss_pkg::lcg_next(w1_reg)) && (m1_reg == rlss_pkg::mod100(w1_reg)))
        else $error("live generator lookahead out of step");

    // The saved generator lookahead stays consistent with its word.
    a_saved_lookahead: assert property (@(posedge clk) disable iff (!rst_n)
        (sw2_reg == rlss_pkg::lcg_next(sw1_reg)) && (sm1_reg == rlss_pkg::mod100(sw1_reg)))
        else $error("saved generator lookahead out of step");

    // Every accepted transaction leaves a result waiting.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |=> result_valid_reg)
        else $error("accepted transaction produced no result");

    // Once started, the sequencer never returns to the first-step state.
    a_started_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg)
        else $error("started flag dropped");

endmodule
